// File: src/ic3_pkg.sv
// ----------------------------------------------------------------------------
// ic3_pkg
// Shared types, constants and kernel weights for the 3x3 image convolution.
// ----------------------------------------------------------------------------
package ic3_pkg;

	localparam int MaxWidth  = 1024;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int WidthW    = 11;
	localparam int HeightW   = 13;
	localparam int RowW      = 13;
	localparam int KselW     = 3;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 13;
	localparam int MinDim    = 3;
	localparam int MaxHeight = 4096;

	localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgKernel = 2'd2;

	localparam logic [KselW-1:0] KSobelH  = 3'd0;
	localparam logic [KselW-1:0] KSobelV  = 3'd1;
	localparam logic [KselW-1:0] KBox     = 3'd2;
	localparam logic [KselW-1:0] KGauss   = 3'd3;
	localparam logic [KselW-1:0] KSharpen = 3'd4;

	localparam logic [WidthW-1:0]  WidthReset  = 11'd1024;
	localparam logic [HeightW-1:0] HeightReset = 13'd768;
	localparam logic [KselW-1:0]   KselReset   = KBox;

	localparam logic signed [3:0] WSobelH [9] = '{1, 2, 1, 0, 0, 0, -1, -2, -1};
	localparam logic signed [3:0] WSobelV [9] = '{1, 0, -1, 2, 0, -2, 1, 0, -1};
	localparam logic signed [3:0] WBox    [9] = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
	localparam logic signed [3:0] WGauss  [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
	localparam logic signed [3:0] WSharp  [9] = '{0, -1, 0, -1, 5, -1, 0, -1, 0};

	typedef struct packed {
		logic       is_pixel;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_end;
	} result_t;

	// one window to filter, with its border flags
	typedef struct packed {
		logic [8:0][23:0] win;
		logic             top_ok;
		logic             bot_ok;
		logic             left_ok;
		logic             right_ok;
		logic             frame_end;
	} job_t;

	function automatic logic signed [3:0] kernel_weight(logic [KselW-1:0] ksel,
			logic [3:0] tap);
		logic signed [3:0] w;
		w = 4'sd0;
		case (ksel)
			KSobelH:  w = WSobelH[tap];
			KSobelV:  w = WSobelV[tap];
			KGauss:   w = WGauss[tap];
			KSharpen: w = WSharp[tap];
			default:  w = WBox[tap];
		endcase
		return w;
	endfunction

endpackage

// File: src/ic3_front.sv
// ----------------------------------------------------------------------------
// ic3_front
// Takes pixel and flush requests, keeps the frame position, the two line
// stores and the 3x3 window, and queues a filter job for every result.
// ----------------------------------------------------------------------------
module ic3_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  ic3_pkg::pixel_t              pixel,
	input  logic                         restart,
	input  logic [ic3_pkg::WidthW-1:0]   width,
	input  logic [ic3_pkg::HeightW-1:0]  height,
	output logic                         push,
	output ic3_pkg::job_t                job,
	input  logic                         full
);

	typedef enum logic {F_IDLE, F_READ} fstate_t;

	fstate_t                      state_q;
	logic [ic3_pkg::ColW-1:0]     col_q, col_s1;
	logic [ic3_pkg::RowW-1:0]     row_q, row_s1;
	logic [23:0]                  newpix_s1;
	logic [23:0]                  t0_q, t1_q;
	logic [8:0][23:0]             win_q, win_next;
	logic [23:0]                  upper_mem  [ic3_pkg::MaxWidth];
	logic [23:0]                  middle_mem [ic3_pkg::MaxWidth];

	logic                         accept, go, new_frame;
	logic [ic3_pkg::RowW-1:0]     row_eff;
	logic [ic3_pkg::ColW-1:0]     col_eff;
	logic                         emit, leave;
	logic [ic3_pkg::RowW-1:0]     qr;
	logic [ic3_pkg::WidthW-1:0]   qc, c_inc;
	logic [ic3_pkg::ColW-1:0]     col_next;
	logic [ic3_pkg::RowW-1:0]     row_next;
	logic                         fend;

	assign pixel_stall = (state_q != F_IDLE);
	assign accept      = pixel_valid && (state_q == F_IDLE);
	// flush only counts once the frame's pixels are all in
	assign go          = accept && (pixel.is_pixel || ({1'b0, row_q} >= {1'b0, height}));
	assign new_frame   = pixel.is_pixel && ({1'b0, row_q} >= {1'b0, height});

	always_comb begin
		row_eff = new_frame ? '0 : row_q;
		col_eff = new_frame ? '0 : col_q;
		if ({1'b0, col_eff} >= width)
			col_eff = '0;
	end

	always_comb begin
		emit = (row_s1 >= 13'd2) || (row_s1 == 13'd1 && col_s1 != '0);
		if (col_s1 == '0) begin
			qr = row_s1 - 13'd2;
			qc = width - 11'd1;
		end else begin
			qr = row_s1 - 13'd1;
			qc = {1'b0, col_s1} - 11'd1;
		end
		fend  = emit && (qr == height - 13'd1) && (qc == width - 11'd1);
		c_inc = {1'b0, col_s1} + 11'd1;
		if (c_inc >= width) begin
			col_next = '0;
			row_next = row_s1 + 13'd1;
		end else begin
			col_next = c_inc[ic3_pkg::ColW-1:0];
			row_next = row_s1;
		end
		if (fend) begin
			col_next = '0;
			row_next = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i*3]   = win_q[i*3+1];
			win_next[i*3+1] = win_q[i*3+2];
		end
		win_next[2] = t0_q;
		win_next[5] = t1_q;
		win_next[8] = newpix_s1;
	end

	assign leave = (state_q == F_READ) && (!emit || !full);
	assign push  = (state_q == F_READ) && emit && !full;

	always_comb begin
		job.win       = win_next;
		job.top_ok    = (qr != '0);
		job.bot_ok    = ({1'b0, qr} + 14'd1) < {1'b0, height};
		job.left_ok   = (qc != '0);
		job.right_ok  = ({1'b0, qc} + 12'd1) < {1'b0, width};
		job.frame_end = fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			win_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (restart) begin
						col_q <= '0;
						row_q <= '0;
					end else if (go) begin
						state_q <= F_READ;
					end
				end
				F_READ: begin
					if (leave) begin
						state_q <= F_IDLE;
						win_q   <= win_next;
						col_q   <= col_next;
						row_q   <= row_next;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			col_s1    <= col_eff;
			row_s1    <= row_eff;
			newpix_s1 <= pixel.is_pixel ? {pixel.in_red, pixel.in_green, pixel.in_blue} : '0;
		end
	end

	// line stores: read when a request starts, written back when the window moves
	always_ff @(posedge clk) begin
		if (go) begin
			t0_q <= upper_mem[col_eff];
			t1_q <= middle_mem[col_eff];
		end
		if (leave) begin
			upper_mem[col_s1]  <= t1_q;
			middle_mem[col_s1] <= newpix_s1;
		end
	end

endmodule

// File: src/ic3_queue.sv
// ----------------------------------------------------------------------------
// ic3_queue
// Two-entry job queue between the window front and the filter back.
// ----------------------------------------------------------------------------
module ic3_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ic3_pkg::job_t din,
	input  logic          pop,
	output ic3_pkg::job_t dout,
	output logic          full,
	output logic          empty
);

	ic3_pkg::job_t mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

// File: src/ic3_back.sv
// ----------------------------------------------------------------------------
// ic3_back
// Weighted sums of one window, a shared bit-serial divide of the three
// channels by the weight sum, clamp and result register.
// ----------------------------------------------------------------------------
module ic3_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       empty,
	input  ic3_pkg::job_t              job,
	output logic                       pop,
	input  logic [ic3_pkg::KselW-1:0]  ksel,
	output logic                       result_valid,
	input  logic                       result_stall,
	output ic3_pkg::result_t           result
);

	typedef enum logic [1:0] {B_IDLE, B_SUM, B_DIV, B_OUT} bstate_t;

	bstate_t             state_q;
	ic3_pkg::job_t       job_q;
	logic [2:0]          neg_q;
	logic [2:0][11:0]    num_q;
	logic [2:0][4:0]     rem_q;
	logic [4:0]          div_q;
	logic [3:0]          step_q;
	logic                out_valid_q;
	ic3_pkg::result_t    result_q;

	logic [8:0]                 tap_on;
	logic signed [6:0]          wsum;
	logic [2:0][13:0]           sums;
	logic signed [3:0]          w;
	logic signed [13:0]         prod;
	logic [2:0][4:0]            rem_sh;
	logic [2:0][7:0]            chan;
	logic                       load_out;

	assign pop          = (state_q == B_IDLE) && !empty;
	assign result_valid = out_valid_q;
	assign result       = result_q;
	assign load_out     = (state_q == B_OUT) && (!out_valid_q || !result_stall);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				tap_on[r*3+c] = !((r == 0 && !job_q.top_ok) || (r == 2 && !job_q.bot_ok) ||
					(c == 0 && !job_q.left_ok) || (c == 2 && !job_q.right_ok));
			end
		end
	end

	always_comb begin
		wsum = '0;
		sums = '0;
		w    = '0;
		prod = '0;
		for (int t = 0; t < 9; t++) begin
			w = ic3_pkg::kernel_weight(ksel, 4'(t));
			if (tap_on[t]) begin
				wsum = wsum + 7'(w);
				for (int ch = 0; ch < 3; ch++) begin
					prod = 14'(w) * $signed({6'b0, job_q.win[t][ch*8 +: 8]});
					sums[ch] = sums[ch] + prod;
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rem_sh[ch] = {rem_q[ch][3:0], num_q[ch][11]};
			if (neg_q[ch])
				chan[ch] = '0;
			else if (num_q[ch] > 12'd255)
				chan[ch] = 8'd255;
			else
				chan[ch] = num_q[ch][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty)
						state_q <= B_SUM;
				end
				B_SUM: begin
					state_q <= B_DIV;
					step_q  <= '0;
				end
				B_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd11)
						state_q <= B_OUT;
				end
				B_OUT: begin
					if (load_out)
						state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= job;
		if (state_q == B_SUM) begin
			// weight sum below one divides by one
			div_q <= (wsum < 7'sd1) ? 5'd1 : wsum[4:0];
			for (int ch = 0; ch < 3; ch++) begin
				neg_q[ch] <= sums[ch][13];
				num_q[ch] <= sums[ch][11:0];
				rem_q[ch] <= '0;
			end
		end
		if (state_q == B_DIV) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (rem_sh[ch] >= div_q) begin
					rem_q[ch] <= rem_sh[ch] - div_q;
					num_q[ch] <= {num_q[ch][10:0], 1'b1};
				end else begin
					rem_q[ch] <= rem_sh[ch];
					num_q[ch] <= {num_q[ch][10:0], 1'b0};
				end
			end
		end
		if (load_out) begin
			result_q.out_red   <= chan[2];
			result_q.out_green <= chan[1];
			result_q.out_blue  <= chan[0];
			result_q.frame_end <= job_q.frame_end;
		end
	end

endmodule

// File: src/image_convolution_3x3.sv
// ----------------------------------------------------------------------------
// image_convolution_3x3
// 3x3 kernel filter on an RGB raster stream with two line stores.
// ----------------------------------------------------------------------------
// The front takes a request, then does the registered line-store read
// before it takes the next, and hands each window to a two-entry queue;
// the back finishes each result (sum, 12 steps of the serial divider,
// result load) before taking the next job, so the divider sets the pace. The
// result for a pixel appears after width+1 further requests; after the last
// pixel of a frame, width+1 flush requests drain the remaining results, the
// last of which carries frame_end. Write configuration only while idle.
module image_convolution_3x3 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  ic3_pkg::pixel_t               pixel,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ic3_pkg::result_t              result,
	input  logic                          cfg_write,
	input  logic [ic3_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ic3_pkg::CfgDataW-1:0]  cfg_data
);

	logic [ic3_pkg::WidthW-1:0]  width_q, width_eff;
	logic [ic3_pkg::HeightW-1:0] height_q, height_eff;
	logic [ic3_pkg::KselW-1:0]   ksel_q;
	logic                        restart;
	logic                        q_push, q_pop, q_full, q_empty;
	ic3_pkg::job_t               q_din, q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ic3_pkg::WidthReset;
			height_q <= ic3_pkg::HeightReset;
			ksel_q   <= ic3_pkg::KselReset;
		end else if (cfg_write) begin
			if (cfg_index == ic3_pkg::CfgWidth)
				width_q <= cfg_data[ic3_pkg::WidthW-1:0];
			if (cfg_index == ic3_pkg::CfgHeight)
				height_q <= cfg_data[ic3_pkg::HeightW-1:0];
			if (cfg_index == ic3_pkg::CfgKernel)
				ksel_q <= cfg_data[ic3_pkg::KselW-1:0];
		end
	end

	assign restart = cfg_write &&
		(cfg_index == ic3_pkg::CfgWidth || cfg_index == ic3_pkg::CfgHeight);

	always_comb begin
		width_eff = width_q;
		if (width_q < ic3_pkg::WidthW'(ic3_pkg::MinDim))
			width_eff = ic3_pkg::WidthW'(ic3_pkg::MinDim);
		else if (width_q > ic3_pkg::WidthW'(ic3_pkg::MaxWidth))
			width_eff = ic3_pkg::WidthW'(ic3_pkg::MaxWidth);
		height_eff = height_q;
		if (height_q < ic3_pkg::HeightW'(ic3_pkg::MinDim))
			height_eff = ic3_pkg::HeightW'(ic3_pkg::MinDim);
		else if (height_q > ic3_pkg::HeightW'(ic3_pkg::MaxHeight))
			height_eff = ic3_pkg::HeightW'(ic3_pkg::MaxHeight);
	end

	ic3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.restart     (restart),
		.width       (width_eff),
		.height      (height_eff),
		.push        (q_push),
		.job         (q_din),
		.full        (q_full)
	);

	ic3_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	ic3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.job          (q_dout),
		.pop          (q_pop),
		.ksel         (ksel_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("job queued while queue full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("job taken from empty queue");

	a_pop_not_during_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |=> !q_empty)
		else $error("queued job lost");

endmodule
